FILE: design/scp_pkg.sv
// ============================================================================
// scp_pkg : shared types and constants for the sparse cell table
// Field widths, result and register codes, and the structs that pass
// between the controller and the row of table cells.
// ============================================================================
package scp_pkg;

    localparam int VALUE_W      = 32;
    localparam int COORD_W      = 16;
    localparam int COUNT_W      = 3;
    localparam int CFG_IDX_W    = 3;
    localparam int NUM_DIM_REGS = 4;

    localparam int CAPACITY_DEF = 64;
    localparam int MAX_DIMS_DEF = 4;

    typedef logic signed [VALUE_W-1:0] value_t;

    // result status codes
    typedef enum logic [1:0] {
        STATUS_OK        = 2'd0,
        STATUS_BAD_COUNT = 2'd1,
        STATUS_BAD_RANGE = 2'd2,
        STATUS_FULL      = 2'd3
    } status_t;

    // configuration register indexes
    typedef enum logic [CFG_IDX_W-1:0] {
        REG_DEFAULT    = 3'd0,
        REG_NUM_DIMS   = 3'd1,
        REG_DIM_SIZE_0 = 3'd2,
        REG_DIM_SIZE_1 = 3'd3,
        REG_DIM_SIZE_2 = 3'd4,
        REG_DIM_SIZE_3 = 3'd5
    } cfg_reg_t;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SEARCH,
        ST_DECIDE
    } state_t;

    // search token handed from cell to cell
    typedef struct packed {
        logic   valid;
        logic   found;
        logic   free_found;
        value_t match_value;
    } tok_t;

    // store into one slot
    typedef struct packed {
        logic   en;
        value_t value;
    } commit_t;

    // drop every entry that holds the new default
    typedef struct packed {
        logic   en;
        value_t value;
    } prune_t;

endpackage

FILE: design/scp_cell.sv
// ============================================================================
// scp_cell : one slot of the sparse cell table
// Holds one entry, checks the passing search token against it and hands
// the token on to the next cell through a register.
// ============================================================================
module scp_cell
    import scp_pkg::*;
#(
    parameter int unsigned INDEX = 0,
    parameter int          IDX_W = 6,
    parameter int          KEY_W = 64
)
(
    input  logic               clk,
    input  logic               rst_n,
    input  tok_t               tok_in,
    input  logic [IDX_W-1:0]   match_idx_in,
    input  logic [IDX_W-1:0]   free_idx_in,
    input  value_t             default_value,
    input  logic [KEY_W-1:0]   acc_key,
    input  logic [COUNT_W-1:0] acc_count,
    input  commit_t            commit,
    input  logic [IDX_W-1:0]   commit_idx,
    input  prune_t             prune,
    output tok_t               tok_out,
    output logic [IDX_W-1:0]   match_idx_out,
    output logic [IDX_W-1:0]   free_idx_out
);

    logic               valid_reg;
    logic [KEY_W-1:0]   key_reg;
    logic [COUNT_W-1:0] count_reg;
    value_t             value_reg;

    tok_t               tok_reg;
    tok_t               tok_next;
    logic [IDX_W-1:0]   match_idx_reg;
    logic [IDX_W-1:0]   match_idx_next;
    logic [IDX_W-1:0]   free_idx_reg;
    logic [IDX_W-1:0]   free_idx_next;

    logic live;
    logic found_here;
    logic free_here;
    logic sel;

    assign live       = valid_reg && (value_reg != default_value);
    assign found_here = tok_in.valid && !tok_in.found && live
                        && (count_reg == acc_count) && (key_reg == acc_key);
    assign free_here  = tok_in.valid && !tok_in.free_found && !live;
    assign sel        = commit.en && (commit_idx == IDX_W'(INDEX));

    always_comb
    begin
        tok_next             = tok_in;
        tok_next.found       = tok_in.found | found_here;
        tok_next.free_found  = tok_in.free_found | free_here;
        tok_next.match_value = found_here ? value_reg : tok_in.match_value;
        match_idx_next       = found_here ? IDX_W'(INDEX) : match_idx_in;
        free_idx_next        = free_here ? IDX_W'(INDEX) : free_idx_in;
    end

    // advance the token
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            tok_reg <= '0;
        end
        else
        begin
            tok_reg <= tok_next;
        end
    end

    always_ff @(posedge clk)
    begin
        match_idx_reg <= match_idx_next;
        free_idx_reg  <= free_idx_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (sel)
        begin
            valid_reg <= 1'b1;
        end
        else if (prune.en && valid_reg && (value_reg == prune.value))
        begin
            valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (sel)
        begin
            key_reg   <= acc_key;
            count_reg <= acc_count;
            value_reg <= commit.value;
        end
    end

    assign tok_out       = tok_reg;
    assign match_idx_out = match_idx_reg;
    assign free_idx_out  = free_idx_reg;

endmodule

FILE: design/scp_chain.sv
// ============================================================================
// scp_chain : row of table cells
// Links the cells so the search token walks from slot 0 to the last slot,
// one slot per cycle; commit and prune reach every cell at once.
// ============================================================================
module scp_chain
    import scp_pkg::*;
#(
    parameter int CAPACITY = CAPACITY_DEF,
    parameter int IDX_W    = 6,
    parameter int KEY_W    = 64
)
(
    input  logic               clk,
    input  logic               rst_n,
    input  tok_t               tok_in,
    input  value_t             default_value,
    input  logic [KEY_W-1:0]   acc_key,
    input  logic [COUNT_W-1:0] acc_count,
    input  commit_t            commit,
    input  logic [IDX_W-1:0]   commit_idx,
    input  prune_t             prune,
    output tok_t               tok_out,
    output logic [IDX_W-1:0]   match_idx_out,
    output logic [IDX_W-1:0]   free_idx_out
);

    tok_t             tok_w   [CAPACITY+1];
    logic [IDX_W-1:0] midx_w  [CAPACITY+1];
    logic [IDX_W-1:0] fidx_w  [CAPACITY+1];

    assign tok_w[0]  = tok_in;
    assign midx_w[0] = '0;
    assign fidx_w[0] = '0;

    for (genvar g = 0; g < CAPACITY; g++)
    begin : g_cell
        scp_cell #(
            .INDEX (g),
            .IDX_W (IDX_W),
            .KEY_W (KEY_W)
        ) u_cell (
            .clk           (clk),
            .rst_n         (rst_n),
            .tok_in        (tok_w[g]),
            .match_idx_in  (midx_w[g]),
            .free_idx_in   (fidx_w[g]),
            .default_value (default_value),
            .acc_key       (acc_key),
            .acc_count     (acc_count),
            .commit        (commit),
            .commit_idx    (commit_idx),
            .prune         (prune),
            .tok_out       (tok_w[g+1]),
            .match_idx_out (midx_w[g+1]),
            .free_idx_out  (fidx_w[g+1])
        );
    end

    assign tok_out       = tok_w[CAPACITY];
    assign match_idx_out = midx_w[CAPACITY];
    assign free_idx_out  = fidx_w[CAPACITY];

endmodule

FILE: design/sparse_cell_table_top.sv
// ============================================================================
// sparse_cell_table_top : bounded coordinate-list sparse matrix
// Checks each access, walks one that passes the checks along a row of cells
// that hold the stored entries, then reads, updates or allocates one slot.
// ============================================================================
// An accepted access is registered, sent into the cell row as a token,
//   captured as the token leaves the last cell and decided into the output
//   register once the result channel is free; a rejected access skips the row.
// The token walks one cell per cycle; in_stall stays high until the decision.
// Reset: controller idle, every slot empty, registers at their reset values;
//   no clearing pass, the first access is taken straight after reset.
module sparse_cell_table_top
    import scp_pkg::*;
#(
    parameter int CAPACITY = CAPACITY_DEF,
    parameter int MAX_DIMS = MAX_DIMS_DEF
)
(
    input  logic                 clk,
    input  logic                 rst_n,
    // access channel
    input  logic                 in_valid,
    output logic                 in_stall,
    input  logic                 action,
    input  logic [COUNT_W-1:0]   coord_count,
    input  logic [COORD_W-1:0]   coord_0,
    input  logic [COORD_W-1:0]   coord_1,
    input  logic [COORD_W-1:0]   coord_2,
    input  logic [COORD_W-1:0]   coord_3,
    input  value_t               write_value,
    // result channel
    output logic                 out_valid,
    input  logic                 out_stall,
    output value_t               read_value,
    output logic                 hit,
    output logic [1:0]           status,
    // configuration write channel
    input  logic                 cfg_valid,
    output logic                 cfg_ready,
    input  logic [CFG_IDX_W-1:0] cfg_index,
    input  logic [VALUE_W-1:0]   cfg_data
);

    localparam int IDX_W = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
    localparam int KEY_W = COORD_W * MAX_DIMS;

    // ------------------------------------------------------------------
    // Configuration registers
    // ------------------------------------------------------------------
    value_t             default_reg;
    logic [COUNT_W-1:0] num_dims_reg;
    logic [COORD_W-1:0] dim_size_reg [NUM_DIM_REGS];

    logic   cfg_acc;
    prune_t prune;

    assign cfg_acc     = cfg_valid && cfg_ready;
    // a new default frees every entry that already holds it
    assign prune.en    = cfg_acc && (cfg_index == REG_DEFAULT);
    assign prune.value = value_t'(cfg_data);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            default_reg  <= '0;
            num_dims_reg <= COUNT_W'(2);
            for (int i = 0; i < NUM_DIM_REGS; i++)
            begin
                dim_size_reg[i] <= '1;
            end
        end
        else if (cfg_acc)
        begin
            unique case (cfg_index)
                REG_DEFAULT:    default_reg     <= value_t'(cfg_data);
                REG_NUM_DIMS:   num_dims_reg    <= cfg_data[COUNT_W-1:0];
                REG_DIM_SIZE_0: dim_size_reg[0] <= cfg_data[COORD_W-1:0];
                REG_DIM_SIZE_1: dim_size_reg[1] <= cfg_data[COORD_W-1:0];
                REG_DIM_SIZE_2: dim_size_reg[2] <= cfg_data[COORD_W-1:0];
                REG_DIM_SIZE_3: dim_size_reg[3] <= cfg_data[COORD_W-1:0];
                default:        ; // drop writes to unknown indexes
            endcase
        end
    end

    // ------------------------------------------------------------------
    // Access checks and key build
    // ------------------------------------------------------------------
    logic [COORD_W-1:0] coord [NUM_DIM_REGS];
    logic               dims_bad;
    logic               range_bad;
    logic [KEY_W-1:0]   key_w;
    status_t            chk_status;

    assign coord[0] = coord_0;
    assign coord[1] = coord_1;
    assign coord[2] = coord_2;
    assign coord[3] = coord_3;

    assign dims_bad = (num_dims_reg == '0)
                      || (num_dims_reg > COUNT_W'(MAX_DIMS))
                      || (coord_count != num_dims_reg);

    always_comb
    begin
        range_bad = 1'b0;
        key_w     = '0;
        for (int i = 0; i < MAX_DIMS; i++)
        begin
            if (COUNT_W'(i) < num_dims_reg)
            begin
                key_w[COORD_W*i +: COORD_W] = coord[i];
                if (coord[i] >= dim_size_reg[i])
                begin
                    range_bad = 1'b1;
                end
            end
        end
    end

    assign chk_status = dims_bad  ? STATUS_BAD_COUNT :
                        range_bad ? STATUS_BAD_RANGE : STATUS_OK;

    // ------------------------------------------------------------------
    // Controller
    // ------------------------------------------------------------------
    state_t state_reg;
    state_t state_next;

    logic in_acc;
    logic out_free;
    logic launch_reg;
    logic launch_next;
    logic capture;
    logic decide;

    tok_t             tok_head;
    tok_t             tok_tail;
    logic [IDX_W-1:0] tail_match_idx;
    logic [IDX_W-1:0] tail_free_idx;

    assign in_acc   = in_valid && !in_stall;
    assign out_free = !out_valid || !out_stall;

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (in_acc)
                begin
                    state_next = (chk_status == STATUS_OK) ? ST_SEARCH : ST_DECIDE;
                end
            end
            ST_SEARCH:
            begin
                if (tok_tail.valid)
                begin
                    state_next = ST_DECIDE;
                end
            end
            ST_DECIDE:
            begin
                if (out_free)
                begin
                    state_next = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    always_comb
    begin
        in_stall    = (state_reg != ST_IDLE);
        cfg_ready   = (state_reg == ST_IDLE);
        launch_next = in_acc && (chk_status == STATUS_OK);
        capture     = (state_reg == ST_SEARCH) && tok_tail.valid;
        decide      = (state_reg == ST_DECIDE) && out_free;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= ST_IDLE;
            launch_reg <= 1'b0;
        end
        else
        begin
            state_reg  <= state_next;
            launch_reg <= launch_next;
        end
    end

    // hold the accepted access for the whole search
    logic               action_reg;
    logic [COUNT_W-1:0] count_reg;
    logic [KEY_W-1:0]   key_reg;
    value_t             wval_reg;
    status_t            err_reg;

    always_ff @(posedge clk)
    begin
        if (in_acc)
        begin
            action_reg <= action;
            count_reg  <= coord_count;
            key_reg    <= key_w;
            wval_reg   <= write_value;
            err_reg    <= chk_status;
        end
    end

    // ------------------------------------------------------------------
    // Cell row
    // ------------------------------------------------------------------
    commit_t          commit;
    logic [IDX_W-1:0] commit_idx;

    always_comb
    begin
        tok_head       = '0;
        tok_head.valid = launch_reg;
    end

    scp_chain #(
        .CAPACITY (CAPACITY),
        .IDX_W    (IDX_W),
        .KEY_W    (KEY_W)
    ) u_chain (
        .clk           (clk),
        .rst_n         (rst_n),
        .tok_in        (tok_head),
        .default_value (default_reg),
        .acc_key       (key_reg),
        .acc_count     (count_reg),
        .commit        (commit),
        .commit_idx    (commit_idx),
        .prune         (prune),
        .tok_out       (tok_tail),
        .match_idx_out (tail_match_idx),
        .free_idx_out  (tail_free_idx)
    );

    // capture the token as it leaves the last cell
    logic             found_reg;
    logic             free_found_reg;
    value_t           mval_reg;
    logic [IDX_W-1:0] match_idx_reg;
    logic [IDX_W-1:0] free_idx_reg;

    always_ff @(posedge clk)
    begin
        if (capture)
        begin
            found_reg      <= tok_tail.found;
            free_found_reg <= tok_tail.free_found;
            mval_reg       <= tok_tail.match_value;
            match_idx_reg  <= tail_match_idx;
            free_idx_reg   <= tail_free_idx;
        end
    end

    // ------------------------------------------------------------------
    // Result and slot update
    // ------------------------------------------------------------------
    value_t  res_value;
    logic    res_hit;
    status_t res_status;

    always_comb
    begin
        res_value    = '0;
        res_hit      = 1'b0;
        res_status   = STATUS_OK;
        commit.en    = 1'b0;
        commit.value = wval_reg;
        commit_idx   = match_idx_reg;
        if (err_reg != STATUS_OK)
        begin
            // rejected access: default on read, nothing stored on write
            res_status = err_reg;
            res_value  = action_reg ? value_t'(0) : default_reg;
        end
        else if (!action_reg)
        begin
            res_hit   = found_reg;
            res_value = found_reg ? mval_reg : default_reg;
        end
        else
        begin
            res_hit = found_reg;
            if (found_reg)
            begin
                commit.en = decide;
            end
            else if (wval_reg != default_reg)
            begin
                if (free_found_reg)
                begin
                    commit.en  = decide;
                    commit_idx = free_idx_reg;
                end
                else
                begin
                    res_status = STATUS_FULL;
                end
            end
        end
    end

    // output register parts the result channel from the search
    logic       out_valid_reg;
    logic       out_valid_next;
    value_t     read_value_reg;
    logic       hit_reg;
    logic [1:0] status_reg;

    assign out_valid_next = decide || (out_valid_reg && out_stall);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (decide)
        begin
            read_value_reg <= res_value;
            hit_reg        <= res_hit;
            status_reg     <= res_status;
        end
    end

    assign out_valid  = out_valid_reg;
    assign read_value = read_value_reg;
    assign hit        = hit_reg;
    assign status     = status_reg;

endmodule

FILE: design/scp_checker.sv
// ============================================================================
// scp_checker : port-level checks for the sparse cell table
// Watches the top-level ports over time; bound to the top level below.
// ============================================================================
module scp_checker
    import scp_pkg::*;
(
    input logic                 clk,
    input logic                 rst_n,
    input logic                 in_valid,
    input logic                 in_stall,
    input logic                 out_valid,
    input logic                 out_stall,
    input value_t               read_value,
    input logic                 hit,
    input logic [1:0]           status
);

    // a matched entry is only reported on an accepted access
    a_hit_ok: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && hit |-> (status == STATUS_OK))
        else $error("hit reported with an error status");

    // one access at a time: busy straight after a transaction
    a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && !in_stall |=> in_stall)
        else $error("input taken again before the access finished");

    // a new result only appears while an access is in flight
    a_result_from_access: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid) |-> $past(in_stall))
        else $error("result without an access in flight");

    // a stalled result holds
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> out_valid && $stable(read_value)
                                   && $stable(hit) && $stable(status))
        else $error("stalled result changed");

endmodule

bind sparse_cell_table_top scp_checker u_scp_checker (.*);
